FILE: hdl/ang_pkg.sv
// Shared constants, codes and types of the audio noise gate.
`timescale 1ns / 1ps
package ang_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DELAY_DEPTH = 256;
  localparam int DELAY_AW    = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int FILL_W      = $clog2(DELAY_DEPTH + 1);
  localparam int DLY_CMP_W   = (FILL_W > 8) ? FILL_W : 8;

  localparam int GAIN_BITS   = 17;
  localparam int STEP_BITS   = 17;
  localparam int WEIGHT_BITS = 17;
  localparam int THR_BITS    = 16;
  localparam int DLEN_BITS   = 8;
  localparam int CFG_BITS    = 17;
  localparam int FRAC_BITS   = 16;

  localparam int AVG_BITS    = SAMPLE_BITS + FRAC_BITS;
  localparam int LVL_W       = (AVG_BITS > THR_BITS + FRAC_BITS) ? AVG_BITS
                                                                 : THR_BITS + FRAC_BITS;

  localparam logic [GAIN_BITS-1:0]   UNITY        = GAIN_BITS'(1 << FRAC_BITS);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_UNITY = WEIGHT_BITS'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    CFG_THRESHOLD      = 2'd0,
    CFG_AVERAGE_WEIGHT = 2'd1,
    CFG_RAMP_STEP      = 2'd2,
    CFG_DELAY_LENGTH   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_AVG,
    ST_GAIN,
    ST_OUT
  } state_t;

endpackage

FILE: hdl/ang_in_if.sv
// Input sample channel of the audio noise gate.
`timescale 1ns / 1ps
interface ang_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ang_pkg::SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

FILE: hdl/ang_out_if.sv
// Result channel of the audio noise gate.
`timescale 1ns / 1ps
interface ang_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ang_pkg::SAMPLE_BITS-1:0] sample_out;
  logic [ang_pkg::GAIN_BITS-1:0]          gain;

  modport source (output valid, output sample_out, output gain, input ready);
  modport sink   (input valid, input sample_out, input gain, output ready);
endinterface

FILE: hdl/ang_delay.sv
// Sample delay memory with write pointer and fill count.
`timescale 1ns / 1ps
module ang_delay (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  logic signed [ang_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [ang_pkg::DLEN_BITS-1:0]          delay_length,
  output logic signed [ang_pkg::SAMPLE_BITS-1:0] delayed
);

  logic [ang_pkg::SAMPLE_BITS-1:0] mem [ang_pkg::DELAY_DEPTH];
  logic [ang_pkg::SAMPLE_BITS-1:0] rdata;
  logic [ang_pkg::SAMPLE_BITS-1:0] fwd;
  logic [ang_pkg::DELAY_AW-1:0]    wp;
  logic [ang_pkg::DELAY_AW-1:0]    rd_addr;
  logic [ang_pkg::FILL_W-1:0]      fill;
  logic [ang_pkg::DLY_CMP_W-1:0]   d_ext;
  logic [ang_pkg::DLY_CMP_W-1:0]   d_sat;
  logic [ang_pkg::DLY_CMP_W-1:0]   wp_ext;
  logic                            sel_fwd;
  logic                            sel_zero;

  always_comb begin
    d_ext  = ang_pkg::DLY_CMP_W'(delay_length);
    d_sat  = (d_ext > ang_pkg::DLY_CMP_W'(ang_pkg::DELAY_DEPTH - 1))
             ? ang_pkg::DLY_CMP_W'(ang_pkg::DELAY_DEPTH - 1) : d_ext;
    wp_ext = ang_pkg::DLY_CMP_W'(wp);
    if (wp_ext >= d_sat) begin
      rd_addr = ang_pkg::DELAY_AW'(wp_ext - d_sat);
    end else begin
      rd_addr = ang_pkg::DELAY_AW'(ang_pkg::DLY_CMP_W'(ang_pkg::DELAY_DEPTH)
                                   - (d_sat - wp_ext));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= sample;
      rdata   <= mem[rd_addr];
      fwd     <= sample;
    end
  end

  // Entries never written read as zero; a delay of zero takes the new sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      fill     <= '0;
      sel_fwd  <= 1'b0;
      sel_zero <= 1'b0;
    end else if (push) begin
      sel_fwd  <= (d_sat == '0);
      sel_zero <= (d_sat > ang_pkg::DLY_CMP_W'(fill));
      if (wp == ang_pkg::DELAY_AW'(ang_pkg::DELAY_DEPTH - 1)) begin
        wp <= '0;
      end else begin
        wp <= wp + 1'b1;
      end
      if (fill != ang_pkg::FILL_W'(ang_pkg::DELAY_DEPTH)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_comb begin
    if (sel_zero) begin
      delayed = '0;
    end else if (sel_fwd) begin
      delayed = fwd;
    end else begin
      delayed = rdata;
    end
  end

endmodule

FILE: hdl/audio_noise_gate.sv
// Top level of the audio noise gate with linear gain ramp.
//
//   channel     | direction | transfer moves
//   ------------+-----------+------------------------------------------
//   sample_ch   | in        | sample_in, one signed audio sample
//   result_ch   | out       | sample_out and gain for that sample
//   cfg port    | in        | cfg_index and cfg_data, written when cfg_we
//
// Each sample passes from its transfer in to its registered result through
// states MAG, AVG, GAIN and OUT: the delay memory is read at the transfer
// edge, then come the magnitude and weighting multiplies, average update,
// gain ramp and output multiply. No new sample is taken until the result
// has been loaded at the end of OUT and the FSM is back in IDLE.
// A new sample is taken while a result still waits; its own result is then
// held back until the waiting one has been transferred.
// Reset restores control state; the delay line reads as zero until written.
`timescale 1ns / 1ps
module audio_noise_gate (
  input  logic                           clk,
  input  logic                           rst,
  ang_in_if.sink                         sample_ch,
  ang_out_if.source                      result_ch,
  input  logic                           cfg_we,
  input  ang_pkg::cfg_index_t            cfg_index,
  input  logic [ang_pkg::CFG_BITS-1:0]   cfg_data
);

  localparam int SB = ang_pkg::SAMPLE_BITS;
  localparam int GB = ang_pkg::GAIN_BITS;
  localparam int AB = ang_pkg::AVG_BITS;

  ang_pkg::state_t state, state_next;

  logic [ang_pkg::THR_BITS-1:0]    threshold;
  logic [ang_pkg::WEIGHT_BITS-1:0] average_weight;
  logic [ang_pkg::STEP_BITS-1:0]   ramp_step;
  logic [ang_pkg::DLEN_BITS-1:0]   delay_length;

  logic                            push;
  logic signed [SB-1:0]            delayed;
  logic signed [SB-1:0]            x;
  logic [SB-1:0]                   mag;
  logic [ang_pkg::WEIGHT_BITS-1:0] w_sat;
  logic [ang_pkg::WEIGHT_BITS-1:0] w_rest;
  logic [SB+ang_pkg::WEIGHT_BITS-1:0] mag_w;
  logic [AB+ang_pkg::WEIGHT_BITS-1:0] avg_keep;
  logic [AB:0]                     avg_sum;
  logic [AB-1:0]                   avg;
  logic [ang_pkg::LVL_W-1:0]       thr_lvl;
  logic                            below;

  logic [GB-1:0]                   gain;
  ang_pkg::dir_t                   dir;
  ang_pkg::dir_t                   dir_set;
  ang_pkg::dir_t                   dir_next;
  logic signed [GB+1:0]            g_move;
  logic [GB-1:0]                   gain_next;

  logic signed [SB+GB:0]           prod;
  logic                            out_valid;
  logic signed [SB-1:0]            sample_out;
  logic [GB-1:0]                   gain_out;
  logic                            out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= '0;
      average_weight <= ang_pkg::WEIGHT_UNITY;
      ramp_step      <= ang_pkg::STEP_BITS'(64);
      delay_length   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ang_pkg::CFG_THRESHOLD:      threshold      <= cfg_data[ang_pkg::THR_BITS-1:0];
        ang_pkg::CFG_AVERAGE_WEIGHT: average_weight <= cfg_data[ang_pkg::WEIGHT_BITS-1:0];
        ang_pkg::CFG_RAMP_STEP:      ramp_step      <= cfg_data[ang_pkg::STEP_BITS-1:0];
        ang_pkg::CFG_DELAY_LENGTH:   delay_length   <= cfg_data[ang_pkg::DLEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  ang_delay u_delay (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .sample       (sample_ch.sample_in),
    .delay_length (delay_length),
    .delayed      (delayed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ang_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    sample_ch.ready = 1'b0;
    out_load        = 1'b0;
    unique case (state)
      ang_pkg::ST_IDLE: begin
        sample_ch.ready = 1'b1;
        if (sample_ch.valid) begin
          state_next = ang_pkg::ST_MAG;
        end
      end
      ang_pkg::ST_MAG:  state_next = ang_pkg::ST_AVG;
      ang_pkg::ST_AVG:  state_next = ang_pkg::ST_GAIN;
      ang_pkg::ST_GAIN: state_next = ang_pkg::ST_OUT;
      ang_pkg::ST_OUT: begin
        if (!out_valid || result_ch.ready) begin
          out_load   = 1'b1;
          state_next = ang_pkg::ST_IDLE;
        end
      end
      default: state_next = ang_pkg::ST_IDLE;
    endcase
  end

  assign push = sample_ch.valid && sample_ch.ready;

  always_comb begin
    w_sat   = (average_weight > ang_pkg::WEIGHT_UNITY) ? ang_pkg::WEIGHT_UNITY
                                                       : average_weight;
    w_rest  = ang_pkg::WEIGHT_UNITY - w_sat;
    mag     = delayed[SB-1] ? SB'(~delayed + 1'b1) : SB'(delayed);
    avg_sum = (AB+1)'(mag_w) + (AB+1)'(avg_keep >> ang_pkg::FRAC_BITS);
    thr_lvl = ang_pkg::LVL_W'({threshold, ang_pkg::FRAC_BITS'(0)});
    below   = ang_pkg::LVL_W'(avg) < thr_lvl;
  end

  always_ff @(posedge clk) begin
    if (state == ang_pkg::ST_MAG) begin
      x        <= delayed;
      mag_w    <= (SB + ang_pkg::WEIGHT_BITS)'(mag)
                  * (SB + ang_pkg::WEIGHT_BITS)'(w_sat);
      avg_keep <= (AB + ang_pkg::WEIGHT_BITS)'(avg)
                  * (AB + ang_pkg::WEIGHT_BITS)'(w_rest);
    end
  end

  always_comb begin
    dir_set = dir;
    if (below && gain == ang_pkg::UNITY) begin
      dir_set = ang_pkg::DIR_DOWN;
    end else if (!below && gain < ang_pkg::UNITY) begin
      dir_set = ang_pkg::DIR_UP;
    end
    case (dir_set)
      ang_pkg::DIR_UP:   g_move = $signed({2'b00, gain}) + $signed({2'b00, ramp_step});
      ang_pkg::DIR_DOWN: g_move = $signed({2'b00, gain}) - $signed({2'b00, ramp_step});
      default:           g_move = $signed({2'b00, gain});
    endcase
    if (g_move <= 0) begin
      gain_next = '0;
      dir_next  = ang_pkg::DIR_HOLD;
    end else if (g_move >= $signed({2'b00, ang_pkg::UNITY})) begin
      gain_next = ang_pkg::UNITY;
      dir_next  = ang_pkg::DIR_HOLD;
    end else begin
      gain_next = g_move[GB-1:0];
      dir_next  = dir_set;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg  <= '0;
      gain <= ang_pkg::UNITY;
      dir  <= ang_pkg::DIR_HOLD;
    end else begin
      if (state == ang_pkg::ST_AVG) begin
        avg <= avg_sum[AB-1:0];
      end
      if (state == ang_pkg::ST_GAIN) begin
        gain <= gain_next;
        dir  <= dir_next;
      end
    end
  end

  assign prod = x * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= prod[SB+ang_pkg::FRAC_BITS-1:ang_pkg::FRAC_BITS];
      gain_out   <= gain;
    end
  end

  assign result_ch.valid      = out_valid;
  assign result_ch.sample_out = sample_out;
  assign result_ch.gain       = gain_out;

endmodule

FILE: tb/tb_audio_noise_gate.sv
// Self-checking testbench for the audio noise gate: random traffic, predictor, result checks.
`timescale 1ns / 1ps
module tb_audio_noise_gate;

  localparam longint GAIN_ONE    = longint'(ang_pkg::UNITY);
  localparam int     CYCLE_LIMIT = 500000;
  localparam int     RAND_PHASES = 14;
  localparam int     PHASE_ITEMS = 125;
  localparam int     SB          = ang_pkg::SAMPLE_BITS;

  typedef struct packed {
    logic signed [ang_pkg::SAMPLE_BITS-1:0] sample_out;
    logic [ang_pkg::GAIN_BITS-1:0]          gain;
  } gated_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we;
  ang_pkg::cfg_index_t          cfg_index;
  logic [ang_pkg::CFG_BITS-1:0] cfg_data;

  ang_in_if  in_ch ();
  ang_out_if out_ch ();

  audio_noise_gate dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (in_ch),
    .result_ch (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Register copies held by the predictor.
  logic [ang_pkg::THR_BITS-1:0]    gate_thr;
  logic [ang_pkg::WEIGHT_BITS-1:0] gate_weight;
  logic [ang_pkg::STEP_BITS-1:0]   gate_step;
  logic [ang_pkg::DLEN_BITS-1:0]   gate_delay;

  // Gate state held by the predictor.
  logic signed [SB-1:0]           delay_mem [ang_pkg::DELAY_DEPTH];
  logic [ang_pkg::DELAY_AW-1:0]   wr_ptr;
  longint unsigned                avg_level;
  longint                         gain_level;
  ang_pkg::dir_t                  ramp_dir;

  logic signed [SB-1:0] samples_to_send [$];
  gated_t               gated_expected [$];

  int  n_errors   = 0;
  int  n_checked  = 0;
  int  n_closes   = 0;
  int  n_opens    = 0;
  int  n_settings = 0;
  int  cycles     = 0;
  bit  in_taken   = 1'b0;
  int  gap_left   = 0;
  int  burst_left = 0;
  int  stall_left = 0;
  int  rx_mode    = 0;
  int  rx_count   = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    if (n_errors <= 30) begin
      $display("MISMATCH at result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    end
  endtask

  function automatic gated_t gate_predict(logic signed [SB-1:0] s);
    gated_t                        r;
    logic [ang_pkg::DELAY_AW-1:0]  rd;
    logic [ang_pkg::DLEN_BITS:0]   dly;
    longint                        x;
    longint unsigned               mag;
    longint unsigned               w;
    longint unsigned               thr_q;
    longint                        prod;
    dly = (int'(gate_delay) > ang_pkg::DELAY_DEPTH - 1)
          ? (ang_pkg::DLEN_BITS+1)'(ang_pkg::DELAY_DEPTH - 1)
          : (ang_pkg::DLEN_BITS+1)'(gate_delay);
    delay_mem[wr_ptr] = s;
    rd = wr_ptr - ang_pkg::DELAY_AW'(dly);
    x = delay_mem[rd];
    wr_ptr = wr_ptr + 1'b1;
    mag = (x < 0) ? -x : x;
    w = (gate_weight > ang_pkg::WEIGHT_UNITY) ? 65536 : gate_weight;
    avg_level = ((mag << 16) * w + avg_level * (65536 - w)) >> 16;
    thr_q = longint'(gate_thr) << 16;
    if (avg_level < thr_q && gain_level == GAIN_ONE) begin
      if (ramp_dir != ang_pkg::DIR_DOWN) n_closes++;
      ramp_dir = ang_pkg::DIR_DOWN;
    end else if (avg_level >= thr_q && gain_level < GAIN_ONE) begin
      if (ramp_dir != ang_pkg::DIR_UP) n_opens++;
      ramp_dir = ang_pkg::DIR_UP;
    end
    if (ramp_dir == ang_pkg::DIR_UP) begin
      gain_level = gain_level + longint'(gate_step);
    end else if (ramp_dir == ang_pkg::DIR_DOWN) begin
      gain_level = gain_level - longint'(gate_step);
    end
    if (gain_level <= 0) begin
      gain_level = 0;
      ramp_dir   = ang_pkg::DIR_HOLD;
    end
    if (gain_level >= GAIN_ONE) begin
      gain_level = GAIN_ONE;
      ramp_dir   = ang_pkg::DIR_HOLD;
    end
    prod = x * gain_level;
    r.sample_out = SB'(prod >>> 16);
    r.gain       = ang_pkg::GAIN_BITS'(gain_level);
    return r;
  endfunction

  // Predict on each input transfer, check each output transfer.
  always @(posedge clk) begin
    gated_t want;
    cycles++;
    if (rst) begin
      foreach (delay_mem[i]) delay_mem[i] = '0;
      wr_ptr     = '0;
      avg_level  = 0;
      gain_level = GAIN_ONE;
      ramp_dir   = ang_pkg::DIR_HOLD;
      in_taken   = 1'b0;
    end else begin
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) gated_expected.push_back(gate_predict(in_ch.sample_in));
      if (out_ch.valid && out_ch.ready) begin
        if (gated_expected.size() == 0) begin
          report_mismatch("unexpected result, sample_out", out_ch.sample_out, 0);
        end else begin
          want = gated_expected.pop_front();
          if (out_ch.sample_out !== want.sample_out) begin
            report_mismatch("sample_out", out_ch.sample_out, want.sample_out);
          end
          if (out_ch.gain !== want.gain) begin
            report_mismatch("gain", out_ch.gain, want.gain);
          end
          n_checked++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding", gated_expected.size());
      $display("tb_audio_noise_gate NOT OK");
      $finish;
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid     <= 1'b0;
      in_ch.sample_in <= '0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (samples_to_send.size() > 0) begin
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= samples_to_send.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: switches between always ready, coin-flip and occasional long stalls.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(5, 20);
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
      endcase
    end
    rx_count++;
    if (rx_count % 300 == 0) rx_mode = $urandom_range(0, 2);
  end

  task automatic set_reg(ang_pkg::cfg_index_t idx, logic [ang_pkg::CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      ang_pkg::CFG_THRESHOLD:      gate_thr    <= val[ang_pkg::THR_BITS-1:0];
      ang_pkg::CFG_AVERAGE_WEIGHT: gate_weight <= val[ang_pkg::WEIGHT_BITS-1:0];
      ang_pkg::CFG_RAMP_STEP:      gate_step   <= val[ang_pkg::STEP_BITS-1:0];
      ang_pkg::CFG_DELAY_LENGTH:   gate_delay  <= val[ang_pkg::DLEN_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_gate(int thr, int weight, int step, int dly);
    set_reg(ang_pkg::CFG_THRESHOLD, ang_pkg::CFG_BITS'(thr));
    set_reg(ang_pkg::CFG_AVERAGE_WEIGHT, ang_pkg::CFG_BITS'(weight));
    set_reg(ang_pkg::CFG_RAMP_STEP, ang_pkg::CFG_BITS'(step));
    set_reg(ang_pkg::CFG_DELAY_LENGTH, ang_pkg::CFG_BITS'(dly));
    n_settings++;
  endtask

  task automatic drain();
    while (samples_to_send.size() != 0 || in_ch.valid || gated_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int remaining;
    int seg_len;
    int kind;
    int amp;
    int thr_amp;
    int v;
    int thr;
    int weight;
    int step;
    int dly;
    cfg_we      = 1'b0;
    cfg_index   = ang_pkg::CFG_THRESHOLD;
    cfg_data    = '0;
    gate_thr    = '0;
    gate_weight = ang_pkg::WEIGHT_UNITY;
    gate_step   = ang_pkg::STEP_BITS'(64);
    gate_delay  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: the gate stays open whatever the level.
    samples_to_send = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd1, 16'sd1,
                        16'sh5555, -16'sd21846, 16'sd100};
    drain();

    // Loud then silent so the gate closes, then loud again so it reopens.
    set_gate(2000, 65536, 16384, 2);
    samples_to_send = '{16'sd20000, -16'sd20000, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                        16'sd0, 16'sd0, 16'sd30000, -16'sd30000, 16'sd30000,
                        16'sd30000, 16'sd30000};
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: set_gate(0, 0, 0, 255);
        1: set_gate(65535, 131071, 131071, 0);
        2: set_gate(32768, 65536, 1, 1);
        3: set_gate(1, 1, 65536, 128);
        4: set_gate(500, 65537, 65535, 3);
        default: begin
          thr    = ($urandom_range(0, 3) == 0) ? int'($urandom() & 17'h1FFFF)
                                               : $urandom_range(0, 6000);
          weight = ($urandom_range(0, 3) == 0) ? int'($urandom() & 17'h1FFFF)
                                               : $urandom_range(256, 65536);
          step   = ($urandom_range(0, 3) == 0) ? int'($urandom() & 17'h1FFFF)
                                               : $urandom_range(1, 4096);
          dly    = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8)
                                               : $urandom_range(0, 255);
          set_gate(thr, weight, step, dly);
        end
      endcase

      // Quiet and loud passages around the threshold, with some raw noise.
      thr_amp   = (gate_thr > 32767) ? 32767 : int'(gate_thr);
      remaining = PHASE_ITEMS;
      while (remaining > 0) begin
        seg_len = $urandom_range(4, 50);
        if (seg_len > remaining) seg_len = remaining;
        remaining -= seg_len;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          amp = $urandom_range(0, thr_amp / 2);
        end else if (kind < 8) begin
          amp = $urandom_range(thr_amp, 32768);
        end else begin
          amp = -1;
        end
        repeat (seg_len) begin
          if (amp < 0) begin
            samples_to_send.push_back(SB'($urandom()));
          end else begin
            v = $urandom_range(0, amp);
            if ($urandom_range(0, 1) == 1) v = -v;
            samples_to_send.push_back(SB'(v));
          end
        end
      end
      drain();
    end

    $display("Checked %0d gated samples across %0d register settings", n_checked, n_settings);
    $display("Gate closed %0d times and reopened %0d times; %0d mismatches",
             n_closes, n_opens, n_errors);
    if (n_errors == 0) begin
      $display("tb_audio_noise_gate OK");
    end else begin
      $display("tb_audio_noise_gate NOT OK");
    end
    $finish;
  end

endmodule
